>>> sv/sql_token_scanner_top_defines.svh
// Assertion macros for the SQL token scanner.
// Depends on nothing; included by sql_token_scanner_top.sv.
`ifndef SQL_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SQL_TOKEN_SCANNER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sts_pkg.sv
// Shared types and keyword table of the SQL token scanner.
// No dependencies; used by sql_token_scanner_top.sv.
package sts_pkg;

    // Request into the scanner: one source byte or the end mark
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } char_item_t;

    typedef enum logic [3:0] {
        TK_EOF     = 4'd0,
        TK_NUMBER  = 4'd1,
        TK_IDENT   = 4'd2,
        TK_KEYWORD = 4'd3,
        TK_STRING  = 4'd4,
        TK_LPAREN  = 4'd5,
        TK_RPAREN  = 4'd6,
        TK_COMMA   = 4'd7,
        TK_SEMI    = 4'd8,
        TK_OP      = 4'd9,
        TK_ERROR   = 4'd10
    } tok_kind_t;

    // Request out of the scanner: one token
    typedef struct packed {
        tok_kind_t   token_kind;
        logic [4:0]  keyword_code;
        logic        has_point;
        logic [30:0] int_value;
        logic [15:0] text_start;
        logic [5:0]  text_length;
        logic [7:0]  op_char;
        logic        op_has_equals;
        logic        last_result;
    } token_t;

    localparam int KW_COUNT = 19;
    localparam int KW_CHARS = 7;

    // Keyword text, first character in the top byte, zero padded
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        {"SELECT", 8'h00}, {"FROM", 24'h0}, {"WHERE", 16'h0}, {"INSERT", 8'h00},
        {"INTO", 24'h0}, {"VALUES", 8'h00}, {"UPDATE", 8'h00}, {"SET", 32'h0},
        {"DELETE", 8'h00}, {"CREATE", 8'h00}, {"TABLE", 16'h0}, {"AND", 32'h0},
        {"OR", 40'h0}, {"NULL", 24'h0}, {"INT", 32'h0}, {"FLOAT", 16'h0},
        {"PRIMARY"}, {"KEY", 32'h0}, {"NOT", 32'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd3, 3'd6, 3'd6,
        3'd5, 3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd7, 3'd3, 3'd3
    };

    // Match upper-cased text against the keyword table: {hit, index}
    function automatic logic [5:0] kw_lookup(input logic [55:0] text, input logic [2:0] len);
        logic       hit;
        logic [4:0] code;
        hit  = 1'b0;
        code = 5'd0;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (KW_LEN[i] == len && KW_TEXT[i] == text) begin
                hit  = 1'b1;
                code = 5'(i);
            end
        end
        return {hit, code};
    endfunction

endpackage

>>> sv/sql_token_scanner_top.sv
// SQL token scanner: byte-wide lexer with a four-entry token queue.
// Depends on sts_pkg and sql_token_scanner_top_defines.svh.
//
// Usage:
//   char_valid/char_ready/char_item carry one request per source byte
//   (kind 0) or the end mark (kind 1). tok_valid/tok_ready/tok_item carry
//   tokens; last_result marks the final token caused by one request.
// Tokens are registered into the queue before they are offered.
// Throughput: one request per cycle while each yields at most one token and tokens are taken.
//   A request may yield two tokens (a pending token closed by a byte that
//   is itself a token, or a pending token plus eof); the output drains one
//   token per cycle, so the tokens of such a request leave one at a time.
// The scan step is one level of mode logic feeding a four-entry token queue;
//   char_ready is high while the queue has room for two tokens.
// Stall: when tok_ready is low, tokens wait in the queue and the scanner
//   keeps taking bytes until the queue has less than two free entries.
// Reset: scanner idle, position zero, queue empty. The end mark also
//   returns the scanner to this state, so the next text starts at zero.
// Positions saturate at MAX_INPUT_LEN-1; text lengths cap at TEXT_MAX-1.
`include "sql_token_scanner_top_defines.svh"

module sql_token_scanner_top #(
    parameter int MAX_INPUT_LEN = 65536,
    parameter int TEXT_MAX      = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  sts_pkg::char_item_t char_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output sts_pkg::token_t     tok_item
);

    localparam int PW = $clog2(MAX_INPUT_LEN);
    localparam int CW = $clog2(TEXT_MAX);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_INPUT_LEN - 1);
    localparam logic [CW-1:0] CNT_CAP  = CW'(TEXT_MAX - 1);
    localparam logic [CW-1:0] KW_LIMIT = CW'(sts_pkg::KW_CHARS);
    localparam logic [30:0]   INT_SAT  = 31'h7FFF_FFFF;
    localparam logic [2:0]    QDEPTH   = 3'd4;
    localparam logic [2:0]    FILL_MAX = 3'd2;

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUMBER,
        M_IDENT,
        M_STRING,
        M_OP
    } mode_t;

    // Scanner state
    mode_t         mode_reg,  mode_next;
    logic [PW-1:0] pos_reg,   pos_next;
    logic [PW-1:0] start_reg, start_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic [30:0]   acc_reg,   acc_next;
    logic          float_reg, float_next;
    logic [55:0]   kwbuf_reg, kwbuf_next;
    logic [7:0]    opc_reg,   opc_next;

    // Token queue
    sts_pkg::token_t q_reg [4];
    logic [1:0]      wr_ptr_reg, wr_ptr_next;
    logic [1:0]      rd_ptr_reg, rd_ptr_next;
    logic [2:0]      fill_reg,   fill_next;

    logic            accept;
    logic            pop;
    logic [7:0]      c;
    logic            c_digit, c_alpha, c_space, c_word;
    logic [7:0]      c_upper;
    logic [PW-1:0]   pos_inc;
    logic            can_grow;
    logic [34:0]     acc_sum;
    logic            flush_valid;
    sts_pkg::token_t flush_tok;
    logic [5:0]      kw_res;
    logic            si_valid;
    sts_pkg::token_t si_tok;
    sts_pkg::token_t res0, res1;
    logic [1:0]      res_n;
    logic [1:0]      push_n;

    // Build a token with the common fields set
    function automatic sts_pkg::token_t mk_tok(input sts_pkg::tok_kind_t k,
                                               input logic [PW-1:0] start,
                                               input logic [5:0] len,
                                               input logic [7:0] opc,
                                               input logic eq);
        sts_pkg::token_t t;
        logic [31:0]     wide;
        wide            = 32'(start);
        t               = '0;
        t.token_kind    = k;
        t.text_start    = wide[15:0];
        t.text_length   = len;
        t.op_char       = opc;
        t.op_has_equals = eq;
        return t;
    endfunction

    function automatic logic [5:0] len6(input logic [CW-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[5:0];
    endfunction

    assign accept     = char_valid && char_ready;
    assign pop        = tok_valid && tok_ready;
    assign char_ready = (fill_reg <= FILL_MAX);
    assign tok_valid  = (fill_reg != 3'd0);
    assign tok_item   = q_reg[rd_ptr_reg];

    // Classify the byte
    assign c       = char_item.char_code;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign c_space = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    assign c_word  = c_alpha || c_digit || (c == CH_UNDER);
    assign c_upper = ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
    assign pos_inc = (pos_reg < POS_LAST) ? (pos_reg + 1'b1) : pos_reg;

    // Number accumulator step: acc * 10 + digit
    assign can_grow = (cnt_reg < CNT_CAP);
    assign acc_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 35'(c[3:0]);

    // Keyword match over the buffered prefix
    assign kw_res = sts_pkg::kw_lookup(kwbuf_reg, cnt_reg[2:0]);

    // Token for the pending text
    always_comb
    begin
        flush_valid = (mode_reg != M_IDLE);
        flush_tok   = '0;
        case (mode_reg)
            M_NUMBER:
            begin
                flush_tok = mk_tok(sts_pkg::TK_NUMBER, start_reg, len6(cnt_reg), 8'd0, 1'b0);
                flush_tok.has_point = float_reg;
                flush_tok.int_value = float_reg ? 31'd0 : acc_reg;
            end
            M_IDENT:
            begin
                if (kw_res[5] && (cnt_reg <= KW_LIMIT))
                begin
                    flush_tok = mk_tok(sts_pkg::TK_KEYWORD, start_reg, len6(cnt_reg),
                                       8'd0, 1'b0);
                    flush_tok.keyword_code = kw_res[4:0];
                end
                else
                begin
                    flush_tok = mk_tok(sts_pkg::TK_IDENT, start_reg, len6(cnt_reg),
                                       8'd0, 1'b0);
                end
            end
            M_STRING:
                flush_tok = mk_tok(sts_pkg::TK_STRING, start_reg, len6(cnt_reg), 8'd0, 1'b0);
            M_OP:
                flush_tok = mk_tok(sts_pkg::TK_OP, start_reg, 6'd1, opc_reg, 1'b0);
            default:
                flush_tok = '0;
        endcase
    end

    // Scanner step: advance state and collect up to two tokens
    always_comb
    begin
        logic do_ext;
        logic do_flush;
        logic do_scan;
        logic do_opeq;

        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        float_next = float_reg;
        kwbuf_next = kwbuf_reg;
        opc_next   = opc_reg;
        do_ext     = 1'b0;
        do_flush   = 1'b0;
        do_scan    = 1'b0;
        do_opeq    = 1'b0;
        si_valid   = 1'b0;
        si_tok     = '0;
        res0       = '0;
        res1       = '0;
        res_n      = 2'd0;

        if (char_item.kind)
        begin
            // End mark: emit pending token, then eof, then back to reset state
            if (flush_valid)
            begin
                res0  = flush_tok;
                res1  = mk_tok(sts_pkg::TK_EOF, pos_reg, 6'd0, 8'd0, 1'b0);
                res_n = 2'd2;
            end
            else
            begin
                res0  = mk_tok(sts_pkg::TK_EOF, pos_reg, 6'd0, 8'd0, 1'b0);
                res_n = 2'd1;
            end
            mode_next  = M_IDLE;
            pos_next   = '0;
            start_next = '0;
            cnt_next   = '0;
            acc_next   = '0;
            float_next = 1'b0;
            kwbuf_next = '0;
            opc_next   = '0;
        end
        else
        begin
            pos_next = pos_inc;
            unique case (mode_reg)
                M_NUMBER:
                begin
                    if (c_digit || (c == CH_DOT))
                        do_ext = 1'b1;
                    else
                    begin
                        do_flush = 1'b1;
                        do_scan  = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (c_word)
                        do_ext = 1'b1;
                    else
                    begin
                        do_flush = 1'b1;
                        do_scan  = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        do_flush  = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                        do_ext = 1'b1;
                end
                M_OP:
                begin
                    if (c == CH_EQ)
                    begin
                        do_opeq   = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_scan  = 1'b1;
                    end
                end
                default:
                    do_scan = 1'b1;
            endcase

            // Extend the pending token by this byte
            if (do_ext)
            begin
                if ((mode_reg == M_NUMBER) && (c == CH_DOT))
                    float_next = 1'b1;
                if (can_grow)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if ((mode_reg == M_NUMBER) && c_digit)
                        acc_next = (acc_sum[34:31] != 4'd0) ? INT_SAT : acc_sum[30:0];
                    if ((mode_reg == M_IDENT) && (cnt_reg < KW_LIMIT))
                        kwbuf_next[55 - 8 * cnt_reg[2:0] -: 8] = c_upper;
                end
            end

            // Scan the byte from idle
            if (do_scan)
            begin
                mode_next = M_IDLE;
                if (c_space)
                    si_valid = 1'b0;
                else if (c_digit || c_alpha || (c == CH_UNDER))
                begin
                    mode_next  = c_digit ? M_NUMBER : M_IDENT;
                    start_next = pos_reg;
                    cnt_next   = CW'(1);
                    acc_next   = c_digit ? 31'(c[3:0]) : 31'd0;
                    float_next = 1'b0;
                    kwbuf_next = c_digit ? 56'd0 : {c_upper, 48'd0};
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next  = M_STRING;
                    start_next = pos_inc;
                    cnt_next   = '0;
                    acc_next   = '0;
                    float_next = 1'b0;
                    kwbuf_next = '0;
                end
                else if ((c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT))
                begin
                    mode_next  = M_OP;
                    start_next = pos_reg;
                    opc_next   = c;
                end
                else
                begin
                    si_valid = 1'b1;
                    unique case (c)
                        CH_LPAR:
                            si_tok = mk_tok(sts_pkg::TK_LPAREN, pos_reg, 6'd0, 8'd0, 1'b0);
                        CH_RPAR:
                            si_tok = mk_tok(sts_pkg::TK_RPAREN, pos_reg, 6'd0, 8'd0, 1'b0);
                        CH_COMMA:
                            si_tok = mk_tok(sts_pkg::TK_COMMA, pos_reg, 6'd0, 8'd0, 1'b0);
                        CH_SEMI:
                            si_tok = mk_tok(sts_pkg::TK_SEMI, pos_reg, 6'd0, 8'd0, 1'b0);
                        CH_STAR:
                            si_tok = mk_tok(sts_pkg::TK_OP, pos_reg, 6'd1, c, 1'b0);
                        default:
                            si_tok = mk_tok(sts_pkg::TK_ERROR, pos_reg, 6'd1, c, 1'b0);
                    endcase
                end
            end

            // Collect tokens in order
            if (do_opeq)
            begin
                res0  = mk_tok(sts_pkg::TK_OP, start_reg, 6'd2, opc_reg, 1'b1);
                res_n = 2'd1;
            end
            else if (do_flush)
            begin
                res0  = flush_tok;
                res_n = 2'd1;
            end
            if (si_valid)
            begin
                if (res_n == 2'd0)
                begin
                    res0  = si_tok;
                    res_n = 2'd1;
                end
                else
                begin
                    res1  = si_tok;
                    res_n = 2'd2;
                end
            end
        end

        // Mark the last token of this request
        if (res_n == 2'd2)
            res1.last_result = 1'b1;
        else
            res0.last_result = 1'b1;
    end

    // Queue pointers and fill
    assign push_n      = accept ? res_n : 2'd0;
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + 2'(pop);
    assign fill_next   = fill_reg + 3'(push_n) - 3'(pop);

    // Hold scanner state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            float_reg  <= 1'b0;
            kwbuf_reg  <= '0;
            opc_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                float_reg <= float_next;
                kwbuf_reg <= kwbuf_next;
                opc_reg   <= opc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Write tokens into the queue
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            q_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    `STS_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= QDEPTH,
                    "token queue overflow")
    `STS_ASSERT_NEXT(a_end_resets, clk, rst_n, accept && char_item.kind,
                     mode_reg == M_IDLE && pos_reg == '0,
                     "end mark did not return scanner to reset state")
    `STS_ASSERT_NOW(a_pair_order, clk, rst_n, push_n == 2'd2,
                    !res0.last_result && res1.last_result,
                    "two-token request marked last on wrong token")

endmodule
